[hw/rtl/phd_pkg.sv]
// Shared types, codes and constants for the pH dosing relay controller.
// No dependencies; used by phd_core and ph_dosing_relay_controller.
package phd_pkg;

  typedef enum logic [2:0] {
    EV_SAMPLE    = 3'd0,
    EV_BTN_A     = 3'd1,
    EV_BTN_B     = 3'd2,
    EV_BTN_C     = 3'd3,
    EV_REMOTE    = 3'd4,
    EV_RELAY_CMD = 3'd5,
    EV_LIMITS    = 3'd6,
    EV_POTS      = 3'd7
  } event_t;

  typedef enum logic [1:0] {
    OPM_AUTO   = 2'd0,
    OPM_MANUAL = 2'd1,
    OPM_CONFIG = 2'd2,
    OPM_INFO   = 2'd3
  } mode_t;

  localparam logic [1:0] PAGE_THRESHOLD = 2'd0;
  localparam logic [1:0] PAGE_SLOPE     = 2'd1;
  localparam logic [1:0] PAGE_INTERCEPT = 2'd2;

  localparam logic [10:0] PH_MAX      = 11'd1400;
  localparam logic [10:0] HALF_STEP   = 11'd50;
  localparam logic [10:0] UPPER_RESET = 11'd850;
  localparam logic [10:0] LOWER_RESET = 11'd650;
  localparam logic [6:0]  POT_MAX     = 7'd100;
  localparam logic [3:0]  RELAYS_ACID = 4'hA;
  localparam logic [3:0]  RELAYS_BASE = 4'h5;
  localparam logic [3:0]  RELAYS_ALL  = 4'hF;
  localparam logic [3:0]  RELAY_LAST  = 4'd4;

  typedef struct packed {
    mode_t       mode;
    logic [1:0]  page;
    logic [3:0]  relays;
    logic [10:0] upper;
    logic [10:0] lower;
  } state_t;

  typedef struct packed {
    event_t             ev;
    logic [10:0]        ph_sample;
    logic               auto_request;
    logic [3:0]         relay_number;
    logic               relay_on;
    logic signed [12:0] new_lower_limit;
    logic signed [12:0] new_upper_limit;
    logic [6:0]         pot_upper;
    logic [6:0]         pot_lower;
  } item_t;

  typedef struct packed {
    state_t st;
    logic   accepted;
    logic   save_request;
  } result_t;

  // round(pot * 28 / 100) half steps, in hundredths. The divide by 100 is a
  // multiply by 5243 / 2^19, exact for every value up to 2850.
  function automatic logic [10:0] pot_to_limit(input logic [6:0] pot);
    logic [6:0]  p;
    logic [11:0] x;
    logic [24:0] prod;
    logic [4:0]  q;
    p    = (pot > POT_MAX) ? POT_MAX : pot;
    x    = 12'(p) * 12'd28 + 12'd50;
    prod = 25'(x) * 25'd5243;
    q    = prod[23:19];
    return (11'(q) << 5) + (11'(q) << 4) + (11'(q) << 1);
  endfunction

endpackage

[hw/rtl/phd_core.sv]
// Next-state and result logic for one event beat.
// Depends on phd_pkg.
module phd_core (
  input  phd_pkg::state_t  st,
  input  phd_pkg::item_t   item,
  output phd_pkg::result_t res
);

  phd_pkg::state_t nxt;
  logic            accepted;
  logic            save;
  logic [3:0]      sel;
  logic            lo_ok;
  logic            hi_ok;
  logic [10:0]     pot_up;
  logic [10:0]     pot_lo;
  logic [10:0]     up_min;
  logic [10:0]     up_fix;

  assign sel = (item.relay_number == 4'd0) ? phd_pkg::RELAYS_ALL
                                           : 4'(4'd1 << (item.relay_number - 4'd1));
  assign lo_ok = !item.new_lower_limit[12] &&
                 (item.new_lower_limit <= $signed({2'b00, phd_pkg::PH_MAX}));
  assign hi_ok = !item.new_upper_limit[12] &&
                 (item.new_upper_limit <= $signed({2'b00, phd_pkg::PH_MAX}));

  assign pot_up = phd_pkg::pot_to_limit(item.pot_upper);
  assign pot_lo = phd_pkg::pot_to_limit(item.pot_lower);
  assign up_min = pot_lo + phd_pkg::HALF_STEP;
  always_comb begin
    up_fix = (pot_up < up_min) ? up_min : pot_up;
    if (up_fix > phd_pkg::PH_MAX) begin
      up_fix = phd_pkg::PH_MAX;
    end
  end

  always_comb begin
    nxt      = st;
    accepted = 1'b0;
    save     = 1'b0;
    case (item.ev)
      phd_pkg::EV_SAMPLE: begin
        if (st.mode == phd_pkg::OPM_AUTO) begin
          if (item.ph_sample > st.upper) begin
            nxt.relays = phd_pkg::RELAYS_ACID;
          end else if (item.ph_sample < st.lower) begin
            nxt.relays = phd_pkg::RELAYS_BASE;
          end else begin
            nxt.relays = 4'd0;
          end
        end
      end
      phd_pkg::EV_BTN_A: begin
        case (st.mode)
          phd_pkg::OPM_AUTO: nxt.mode = phd_pkg::OPM_MANUAL;
          phd_pkg::OPM_INFO: nxt.mode = phd_pkg::OPM_AUTO;
          default: begin
            nxt.mode   = phd_pkg::OPM_INFO;
            nxt.relays = 4'd0;
          end
        endcase
      end
      phd_pkg::EV_BTN_B: begin
        if (st.mode == phd_pkg::OPM_INFO) begin
          nxt.mode   = phd_pkg::OPM_CONFIG;
          nxt.page   = phd_pkg::PAGE_THRESHOLD;
          nxt.relays = 4'd0;
        end else if (st.mode == phd_pkg::OPM_CONFIG &&
                     st.page == phd_pkg::PAGE_THRESHOLD) begin
          nxt.mode = phd_pkg::OPM_INFO;
          save     = 1'b1;
        end
      end
      phd_pkg::EV_BTN_C: begin
        if (st.mode == phd_pkg::OPM_INFO) begin
          nxt.mode   = phd_pkg::OPM_CONFIG;
          nxt.page   = phd_pkg::PAGE_SLOPE;
          nxt.relays = 4'd0;
        end else if (st.mode == phd_pkg::OPM_CONFIG &&
                     (st.page == phd_pkg::PAGE_SLOPE ||
                      st.page == phd_pkg::PAGE_INTERCEPT)) begin
          nxt.mode = phd_pkg::OPM_INFO;
          save     = 1'b1;
        end
      end
      phd_pkg::EV_REMOTE: begin
        if (item.auto_request) begin
          nxt.mode = phd_pkg::OPM_AUTO;
        end else begin
          nxt.mode   = phd_pkg::OPM_MANUAL;
          nxt.relays = 4'd0;
        end
      end
      phd_pkg::EV_RELAY_CMD: begin
        if (st.mode == phd_pkg::OPM_MANUAL && item.relay_number <= phd_pkg::RELAY_LAST) begin
          nxt.relays = item.relay_on ? (st.relays | sel) : (st.relays & ~sel);
          accepted   = 1'b1;
        end
      end
      phd_pkg::EV_LIMITS: begin
        if (lo_ok) begin
          nxt.lower = item.new_lower_limit[10:0];
          save      = 1'b1;
        end
        if (hi_ok) begin
          nxt.upper = item.new_upper_limit[10:0];
          save      = 1'b1;
        end
      end
      phd_pkg::EV_POTS: begin
        if (st.mode == phd_pkg::OPM_CONFIG && st.page == phd_pkg::PAGE_THRESHOLD) begin
          nxt.upper = up_fix;
          nxt.lower = pot_lo;
        end
      end
      default: begin
        nxt = st;
      end
    endcase
  end

  assign res.st           = nxt;
  assign res.accepted     = accepted;
  assign res.save_request = save;

endmodule

[hw/rtl/ph_dosing_relay_controller.sv]
// pH dosing relay controller top: input register, phd_core, result register; uses phd_pkg.
// A beat taken into the input register passes through phd_core into the result register, which drives the out_ ports.
// Throughput: one beat per cycle while out_stall is low, set by the single pass through phd_core.
// The input register keeps taking beats while a result waits, until both stages are full.
// Reset (rst_n low, synchronous): AUTO mode, threshold page, relays off,
// limits 8.50 / 6.50, both stages empty.
module ph_dosing_relay_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_mode,
  input  logic [10:0]        in_ph_sample,
  input  logic               in_auto_request,
  input  logic [3:0]         in_relay_number,
  input  logic               in_relay_on,
  input  logic signed [12:0] in_new_lower_limit,
  input  logic signed [12:0] in_new_upper_limit,
  input  logic [6:0]         in_pot_upper,
  input  logic [6:0]         in_pot_lower,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_relay_mask,
  output logic [1:0]         out_operating_mode,
  output logic [1:0]         out_config_page,
  output logic               out_accepted,
  output logic               out_save_request,
  output logic [10:0]        out_upper_limit,
  output logic [10:0]        out_lower_limit
);

  logic             in_v_r;
  phd_pkg::item_t   item_r;
  phd_pkg::state_t  st_r;
  logic             out_v_r;
  phd_pkg::result_t res_r;
  phd_pkg::result_t res_nxt;
  logic             advance;
  logic             take;

  // item moves to the result stage when that stage is empty or drains this cycle
  assign advance  = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !advance;
  assign take     = in_valid && !in_stall;

  phd_core u_core (
    .st   (st_r),
    .item (item_r),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      st_r.mode   <= phd_pkg::OPM_AUTO;
      st_r.page   <= phd_pkg::PAGE_THRESHOLD;
      st_r.relays <= 4'd0;
      st_r.upper  <= phd_pkg::UPPER_RESET;
      st_r.lower  <= phd_pkg::LOWER_RESET;
    end else begin
      if (take) begin
        in_v_r <= 1'b1;
      end else if (advance) begin
        in_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r <= 1'b1;
        st_r    <= res_nxt.st;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.ev              <= phd_pkg::event_t'(in_mode);
      item_r.ph_sample       <= in_ph_sample;
      item_r.auto_request    <= in_auto_request;
      item_r.relay_number    <= in_relay_number;
      item_r.relay_on        <= in_relay_on;
      item_r.new_lower_limit <= in_new_lower_limit;
      item_r.new_upper_limit <= in_new_upper_limit;
      item_r.pot_upper       <= in_pot_upper;
      item_r.pot_lower       <= in_pot_lower;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_v_r;
  assign out_relay_mask     = res_r.st.relays;
  assign out_operating_mode = res_r.st.mode;
  assign out_config_page    = res_r.st.page;
  assign out_accepted       = res_r.accepted;
  assign out_save_request   = res_r.save_request;
  assign out_upper_limit    = res_r.st.upper;
  assign out_lower_limit    = res_r.st.lower;

`ifndef SYNTHESIS
  a_limits_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.upper <= phd_pkg::PH_MAX) && (st_r.lower <= phd_pkg::PH_MAX))
    else $error("pH limit out of range");

  a_accept_manual: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_operating_mode == phd_pkg::OPM_MANUAL)
    else $error("relay command accepted outside MANUAL");

  a_relays_off_menu: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_operating_mode == phd_pkg::OPM_CONFIG ||
                  out_operating_mode == phd_pkg::OPM_INFO) |-> out_relay_mask == 4'd0)
    else $error("relays on in CONFIG or INFO");

  a_held_beat_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !advance |=> in_v_r && $stable(item_r))
    else $error("held input beat lost");
`endif

endmodule
